>>> hdl/warh_pkg.sv
// shared widths, codes and controller/datapath interface types for the histogram core
package warh_pkg;

    localparam int VEL_W      = 32;
    localparam int WGT_W      = 32;
    localparam int BC_W       = 7;
    localparam int INV_W      = 32;
    localparam int K_W        = 6;
    localparam int DENS_W     = 48;
    localparam int DEN_W      = 33;
    localparam int LOW_W      = 64;
    localparam int STEP_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 88;

    localparam int DEF_MAX_PARTICLES = 4096;
    localparam int DEF_MAX_BINS      = 64;

    localparam logic [BC_W-1:0]  BIN_COUNT_RST = 7'd64;
    localparam logic [INV_W-1:0] INV_VOL_RST   = 32'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VOL   = 1'b1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;
    localparam logic KIND_BIN   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [STEP_W-1:0] LOC_STEPS  = 7'd6;
    localparam logic [STEP_W-1:0] EDGE_STEPS = 7'd33;
    localparam logic [STEP_W-1:0] NORM_STEPS = 7'd64;

    localparam logic [DENS_W-1:0] DENS_MAX = '1;

    // controller to datapath commands
    typedef struct packed {
        logic acc_load;
        logic acc_query;
        logic setup;
        logic clr_we;
        logic idx_clr;
        logic idx_inc;
        logic st_rd;
        logic loc_prep;
        logic loc_query;
        logic loc_start;
        logic loc_take;
        logic sum_rd;
        logic sum_acc;
        logic n_rd;
        logic n_mul0;
        logic n_mul1;
        logic n_mul2;
        logic n_add;
        logic n_start;
        logic n_wr;
        logic k_from_idx;
        logic e_start;
        logic e_take;
        logic d_rd;
        logic out_load;
        logic out_query;
        logic out_last;
        logic end_run;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic loc_short;
        logic n_sat;
        logic idx_last_clr;
        logic idx_last_part;
        logic idx_last_bin;
        logic idx_ge_n;
        logic count_zero;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/warh_div.sv
// shared restoring divider, one quotient bit per cycle
module warh_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [warh_pkg::DEN_W-1:0]    i_rem,
    input  logic [warh_pkg::LOW_W-1:0]    i_low,
    input  logic [warh_pkg::STEP_W-1:0]   i_steps,
    input  logic [warh_pkg::DEN_W-1:0]    i_den,
    output logic [warh_pkg::LOW_W-1:0]    o_q,
    output logic                          o_done,
    output logic                          o_busy
);
    import warh_pkg::*;

    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [LOW_W-1:0]  r_low;
    logic [LOW_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    w_trial;
    logic              w_ge;

    // one trial subtraction
    always_comb begin
        w_trial = {r_rem, r_low[LOW_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        n_rem   = w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[LOW_W-2:0], 1'b0};
            r_q   <= {r_q[LOW_W-2:0], w_ge};
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;
    assign o_busy = r_busy;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider busy with zero count");
`endif

endmodule

>>> hdl/warh_ctrl.sv
// sequencer for loading, binning, normalization, reports and queries
module warh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,   // req_type
    input  logic             s_tlast,   // last_particle
    input  warh_pkg::t_sts   i_sts,
    output warh_pkg::t_cmd   o_cmd
);
    import warh_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE   = 22'(1 << 0),
        S_SETUP  = 22'(1 << 1),
        S_CLR    = 22'(1 << 2),
        S_PRD    = 22'(1 << 3),
        S_LPREP  = 22'(1 << 4),
        S_LSTART = 22'(1 << 5),
        S_LWAIT  = 22'(1 << 6),
        S_SRD    = 22'(1 << 7),
        S_SACC   = 22'(1 << 8),
        S_NRD    = 22'(1 << 9),
        S_NMUL0  = 22'(1 << 10),
        S_NMUL1  = 22'(1 << 11),
        S_NMUL2  = 22'(1 << 12),
        S_NADD   = 22'(1 << 13),
        S_NSTART = 22'(1 << 14),
        S_NWAIT  = 22'(1 << 15),
        S_NWR    = 22'(1 << 16),
        S_KSET   = 22'(1 << 17),
        S_ESTART = 22'(1 << 18),
        S_EWAIT  = 22'(1 << 19),
        S_DRD    = 22'(1 << 20),
        S_OUT    = 22'(1 << 21)
    } t_state;

    t_state r_state, n_state;
    logic   r_qmode, n_qmode;
    logic   w_acc;

    assign s_tready = (r_state == S_IDLE);
    assign w_acc    = s_tvalid && s_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_qmode = r_qmode;
        o_cmd   = '0;
        o_cmd.loc_query = r_qmode;
        o_cmd.out_query = r_qmode;
        o_cmd.out_last  = r_qmode || i_sts.idx_last_bin;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (s_tuser == REQ_QUERY) begin
                        o_cmd.acc_query = 1'b1;
                        n_qmode = 1'b1;
                        n_state = S_LPREP;
                    end else begin
                        o_cmd.acc_load = 1'b1;
                        n_qmode = 1'b0;
                        if (s_tlast) begin
                            n_state = S_SETUP;
                        end
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup   = 1'b1;
                o_cmd.idx_clr = 1'b1;
                n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.idx_last_clr) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = i_sts.count_zero ? S_NRD : S_PRD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_PRD: begin
                o_cmd.st_rd = 1'b1;
                n_state = S_LPREP;
            end
            S_LPREP: begin
                o_cmd.loc_prep = 1'b1;
                n_state = S_LSTART;
            end
            S_LSTART: begin
                o_cmd.loc_start = 1'b1;
                if (!i_sts.loc_short) begin
                    n_state = S_LWAIT;
                end else begin
                    n_state = r_qmode ? S_ESTART : S_SRD;
                end
            end
            S_LWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.loc_take = 1'b1;
                    n_state = r_qmode ? S_ESTART : S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.sum_rd = 1'b1;
                n_state = S_SACC;
            end
            S_SACC: begin
                o_cmd.sum_acc = 1'b1;
                if (i_sts.idx_last_part) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_NRD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_NRD: begin
                o_cmd.n_rd = 1'b1;
                n_state = i_sts.idx_ge_n ? S_NWR : S_NMUL0;
            end
            S_NMUL0: begin
                o_cmd.n_mul0 = 1'b1;
                n_state = S_NMUL1;
            end
            S_NMUL1: begin
                o_cmd.n_mul1 = 1'b1;
                n_state = S_NMUL2;
            end
            S_NMUL2: begin
                o_cmd.n_mul2 = 1'b1;
                n_state = S_NADD;
            end
            S_NADD: begin
                o_cmd.n_add = 1'b1;
                n_state = S_NSTART;
            end
            S_NSTART: begin
                if (i_sts.n_sat) begin
                    n_state = S_NWR;
                end else begin
                    o_cmd.n_start = 1'b1;
                    n_state = S_NWAIT;
                end
            end
            S_NWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_NWR;
                end
            end
            S_NWR: begin
                o_cmd.n_wr = 1'b1;
                if (i_sts.idx_last_clr) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_KSET;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_NRD;
                end
            end
            S_KSET: begin
                o_cmd.k_from_idx = 1'b1;
                n_state = S_ESTART;
            end
            S_ESTART: begin
                o_cmd.e_start = 1'b1;
                n_state = S_EWAIT;
            end
            S_EWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.e_take = 1'b1;
                    n_state = S_DRD;
                end
            end
            S_DRD: begin
                o_cmd.d_rd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_qmode) begin
                        n_state = S_IDLE;
                    end else if (i_sts.idx_last_bin) begin
                        o_cmd.end_run = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_KSET;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_qmode <= 1'b0;
        end else begin
            r_state <= n_state;
            r_qmode <= n_qmode;
        end
    end

endmodule

>>> hdl/warh_dp.sv
// datapath: particle stores, trackers, bin sums, densities, operands and output word
module warh_dp #(
    parameter int MAX_PARTICLES = warh_pkg::DEF_MAX_PARTICLES,
    parameter int MAX_BINS      = warh_pkg::DEF_MAX_BINS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [warh_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [warh_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [warh_pkg::S_DATA_W-1:0]      i_s_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [warh_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  warh_pkg::t_cmd                     i_cmd,
    output warh_pkg::t_sts                     o_sts,
    output logic                               o_div_start,
    output logic [warh_pkg::DEN_W-1:0]         o_div_rem,
    output logic [warh_pkg::LOW_W-1:0]         o_div_low,
    output logic [warh_pkg::STEP_W-1:0]        o_div_steps,
    output logic [warh_pkg::DEN_W-1:0]         o_div_den,
    input  logic [warh_pkg::LOW_W-1:0]         i_div_q,
    input  logic                               i_div_done
);
    import warh_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int AW     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int BAW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int IDX_W  = (CNT_W > BC_W) ? CNT_W : BC_W;
    localparam int SUM_W  = WGT_W + CNT_W;
    localparam int A_W    = SUM_W + BC_W;
    localparam int AHI_W  = A_W - 32;
    localparam int PROD_W = A_W + INV_W;
    localparam int HI_W   = PROD_W - LOW_W;
    localparam int LOCN_W = DEN_W + BC_W;
    localparam int EN_W   = K_W + DEN_W;

    // configuration
    logic [BC_W-1:0]  r_bin_count;
    logic [INV_W-1:0] r_inv;

    // particle stores
    logic [VEL_W-1:0] mem_v [MAX_PARTICLES];
    logic [WGT_W-1:0] mem_w [MAX_PARTICLES];
    logic [VEL_W-1:0] r_st_v;
    logic [WGT_W-1:0] r_st_w;

    // run trackers
    logic [CNT_W-1:0]        r_count;
    logic signed [VEL_W-1:0] r_vmin, r_vmax;
    logic signed [VEL_W-1:0] r_qv;

    // built histogram parameters
    logic [BC_W-1:0]         r_bn;
    logic                    r_bdeg;
    logic signed [VEL_W-1:0] r_bmin;
    logic [DEN_W-1:0]        r_brange;
    logic                    r_built;

    // pass state
    logic [IDX_W-1:0]  r_idx;
    logic [SUM_W-1:0]  mem_sum [MAX_BINS];
    logic [SUM_W-1:0]  r_sum_rd;
    logic [DENS_W-1:0] mem_dens [MAX_BINS];
    logic [DENS_W-1:0] r_dens_rd;
    logic [K_W-1:0]    r_k;
    logic              r_loc_short;
    logic [K_W-1:0]    r_loc_k;
    logic [LOCN_W-1:0] r_locn;
    logic [A_W-1:0]    r_a;
    logic [63:0]       r_p0;
    logic [AHI_W+INV_W-1:0] r_p1;
    logic [PROD_W-1:0] r_prod;
    logic [VEL_W-1:0]  r_edge;

    // output word
    logic              r_m_valid;
    logic              r_m_kind;
    logic [K_W-1:0]    r_m_k;
    logic [VEL_W-1:0]  r_m_edge;
    logic [DENS_W-1:0] r_m_dens;
    logic              r_m_deg;
    logic              r_m_last;

    // input fields
    logic signed [VEL_W-1:0] w_in_v;
    logic [WGT_W-1:0]        w_in_w;
    logic                    w_in_alive;
    logic                    w_store;

    assign w_in_v     = $signed(i_s_data[VEL_W-1:0]);
    assign w_in_w     = i_s_data[VEL_W+WGT_W-1:VEL_W];
    assign w_in_alive = i_s_data[VEL_W+WGT_W];
    assign w_store    = i_cmd.acc_load && w_in_alive
                        && (r_count < CNT_W'(MAX_PARTICLES));

    // pass setup values
    logic [BC_W-1:0]  w_n;
    logic             w_degen;
    logic [DEN_W-1:0] w_span;

    always_comb begin
        if (r_bin_count == '0) begin
            w_n = BC_W'(1);
        end else if (r_bin_count > BC_W'(MAX_BINS)) begin
            w_n = BC_W'(MAX_BINS);
        end else begin
            w_n = r_bin_count;
        end
        w_span  = {r_vmax[VEL_W-1], r_vmax} - {r_vmin[VEL_W-1], r_vmin};
        w_degen = (r_count == '0) || (r_vmax == r_vmin);
    end

    // locate operands
    logic signed [VEL_W-1:0] w_lv;
    logic [DEN_W:0]          w_d;
    logic                    w_dneg;
    logic                    w_dtop;

    always_comb begin
        w_lv   = i_cmd.loc_query ? r_qv : $signed(r_st_v);
        w_d    = {{2{w_lv[VEL_W-1]}}, w_lv} - {{2{r_bmin[VEL_W-1]}}, r_bmin};
        w_dneg = w_d[DEN_W];
        w_dtop = w_d[DEN_W-1:0] >= r_brange;
    end

    // normalization overflow check and density value
    logic [HI_W-1:0]   w_hi;
    logic              w_nsat;
    logic [DENS_W-1:0] w_dens;
    logic [EN_W-1:0]   w_en;

    always_comb begin
        w_hi   = r_prod[PROD_W-1:LOW_W];
        w_nsat = {{(DEN_W-HI_W){1'b0}}, w_hi} >= r_brange;
        if (o_sts.idx_ge_n) begin
            w_dens = '0;
        end else if (w_nsat || (i_div_q[LOW_W-1:DENS_W] != '0)) begin
            w_dens = DENS_MAX;
        end else begin
            w_dens = i_div_q[DENS_W-1:0];
        end
        w_en = EN_W'(r_k) * EN_W'(r_brange);
    end

    // divider operand select
    always_comb begin
        o_div_start = (i_cmd.loc_start && !r_loc_short) || i_cmd.n_start || i_cmd.e_start;
        if (i_cmd.e_start) begin
            o_div_rem   = {{(DEN_W-K_W){1'b0}}, w_en[EN_W-1:DEN_W]};
            o_div_low   = {w_en[DEN_W-1:0], {(LOW_W-DEN_W){1'b0}}};
            o_div_steps = EDGE_STEPS;
            o_div_den   = DEN_W'(r_bn);
        end else if (i_cmd.n_start) begin
            o_div_rem   = {{(DEN_W-HI_W){1'b0}}, w_hi};
            o_div_low   = r_prod[LOW_W-1:0];
            o_div_steps = NORM_STEPS;
            o_div_den   = r_brange;
        end else begin
            o_div_rem   = r_locn[LOCN_W-2:K_W];
            o_div_low   = {r_locn[K_W-1:0], {(LOW_W-K_W){1'b0}}};
            o_div_steps = LOC_STEPS;
            o_div_den   = r_brange;
        end
    end

    // status
    always_comb begin
        o_sts.div_done      = i_div_done;
        o_sts.loc_short     = r_loc_short;
        o_sts.n_sat         = w_nsat;
        o_sts.idx_last_clr  = r_idx == IDX_W'(MAX_BINS - 1);
        o_sts.idx_last_part = r_idx == IDX_W'(r_count) - 1'b1;
        o_sts.idx_last_bin  = r_idx == IDX_W'(r_bn) - 1'b1;
        o_sts.idx_ge_n      = r_idx >= IDX_W'(r_bn);
        o_sts.count_zero    = r_count == '0;
        o_sts.out_free      = !r_m_valid || m_tready;
    end

    // particle store write and read
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem_v[r_count[AW-1:0]] <= w_in_v;
            mem_w[r_count[AW-1:0]] <= w_in_w;
        end
        if (i_cmd.st_rd) begin
            r_st_v <= mem_v[r_idx[AW-1:0]];
            r_st_w <= mem_w[r_idx[AW-1:0]];
        end
    end

    // bin sum memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            mem_sum[r_idx[BAW-1:0]] <= '0;
        end else if (i_cmd.sum_acc) begin
            mem_sum[r_k[BAW-1:0]] <= r_sum_rd + SUM_W'(r_st_w);
        end
        if (i_cmd.sum_rd) begin
            r_sum_rd <= mem_sum[r_k[BAW-1:0]];
        end else if (i_cmd.n_rd) begin
            r_sum_rd <= mem_sum[r_idx[BAW-1:0]];
        end
    end

    // density memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.n_wr) begin
            mem_dens[r_idx[BAW-1:0]] <= w_dens;
        end
        if (i_cmd.d_rd) begin
            r_dens_rd <= mem_dens[r_k[BAW-1:0]];
        end
    end

    // configuration, trackers, built parameters and pass index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= BIN_COUNT_RST;
            r_inv       <= INV_VOL_RST;
            r_count     <= '0;
            r_vmin      <= {1'b0, {(VEL_W-1){1'b1}}};
            r_vmax      <= {1'b1, {(VEL_W-1){1'b0}}};
            r_bn        <= BC_W'(1);
            r_bdeg      <= 1'b1;
            r_bmin      <= '0;
            r_brange    <= DEN_W'(1);
            r_built     <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_BIN_COUNT: r_bin_count <= i_cfg_wdata[BC_W-1:0];
                    REG_INV_VOL:   r_inv <= i_cfg_wdata[INV_W-1:0];
                    default: ;
                endcase
            end
            if (w_store) begin
                r_count <= r_count + 1'b1;
                if (w_in_v < r_vmin) r_vmin <= w_in_v;
                if (w_in_v > r_vmax) r_vmax <= w_in_v;
            end
            if (i_cmd.setup) begin
                r_bn     <= w_n;
                r_bdeg   <= w_degen;
                r_bmin   <= (r_count == '0) ? '0 : r_vmin;
                r_brange <= w_degen ? DEN_W'(w_n) : w_span;
                r_built  <= 1'b1;
            end
            if (i_cmd.end_run) begin
                r_count <= '0;
                r_vmin  <= {1'b0, {(VEL_W-1){1'b1}}};
                r_vmax  <= {1'b1, {(VEL_W-1){1'b0}}};
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // locate, normalization and edge operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_query) begin
            r_qv <= w_in_v;
        end
        if (i_cmd.loc_prep) begin
            r_loc_short <= w_dneg || w_dtop;
            r_loc_k     <= w_dneg ? '0 : K_W'(r_bn - 1'b1);
            r_locn      <= LOCN_W'(w_d[DEN_W-1:0]) * LOCN_W'(r_bn);
        end
        if (i_cmd.loc_start && r_loc_short) begin
            r_k <= r_loc_k;
        end else if (i_cmd.loc_take) begin
            r_k <= i_div_q[K_W-1:0];
        end else if (i_cmd.k_from_idx) begin
            r_k <= r_idx[K_W-1:0];
        end
        if (i_cmd.n_mul0) begin
            r_a <= A_W'(r_sum_rd) * A_W'(r_bn);
        end
        if (i_cmd.n_mul1) begin
            r_p0 <= 64'(r_a[31:0]) * 64'(r_inv);
        end
        if (i_cmd.n_mul2) begin
            r_p1 <= (AHI_W+INV_W)'(r_a[A_W-1:32]) * (AHI_W+INV_W)'(r_inv);
        end
        if (i_cmd.n_add) begin
            r_prod <= PROD_W'(r_p0) + {r_p1, 32'd0};
        end
        if (i_cmd.e_take) begin
            r_edge <= r_bmin + i_div_q[VEL_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_kind <= i_cmd.out_query ? KIND_QUERY : KIND_BIN;
            r_m_k    <= r_k;
            r_m_edge <= r_edge;
            r_m_dens <= r_built ? r_dens_rd : '0;
            r_m_deg  <= r_bdeg;
            r_m_last <= i_cmd.out_last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_kind;
    assign m_tlast  = r_m_last;
    assign m_tdata  = {{(M_DATA_W-K_W-VEL_W-DENS_W-1){1'b0}},
                       r_m_deg, r_m_dens, r_m_edge, r_m_k};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PARTICLES)) else $error("particle count overflow");
    a_bin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.loc_take || (i_cmd.loc_start && r_loc_short)) |=> BC_W'(r_k) < r_bn)
        else $error("located bin beyond bin count");
    a_range_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brange != '0) else $error("zero bin range");
`endif

endmodule

>>> hdl/weighted_auto_range_histogram_core.sv
// top level of the weighted auto-range velocity histogram
//
// Input words arrive on the s_ channel. tuser 0 loads a particle: a live one
// is stored and widens the min/max span, a dead one is dropped. tlast on a load
// word starts the pass: bin sums are cleared, each stored particle is located
// and added, every bin is scaled using the shared one-bit-per-cycle divider,
// then one report word per bin leaves on the m_ channel, its lower edge also
// computed by that divider. tuser 1 is a query: it gets one answer word. The
// input is not ready while a pass or a query is running.
// Results wait in an output register; a stalled receiver holds the word and
// stops the pass at the next report. Once the last report or a query answer
// sits in the register the input is ready again and loads can be taken.
// The user makes configuration writes only while the block is idle; not enforced.
// Synchronous reset clears the run, restores register defaults and leaves an
// empty degenerate histogram; the particle stores need no clearing.
module weighted_auto_range_histogram_core #(
    parameter int MAX_PARTICLES = warh_pkg::DEF_MAX_PARTICLES,
    parameter int MAX_BINS      = warh_pkg::DEF_MAX_BINS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [warh_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [warh_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [warh_pkg::S_DATA_W-1:0]     s_tdata,   // velocity, weight, alive
    input  logic                              s_tuser,   // req_type
    input  logic                              s_tlast,   // last_particle
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [warh_pkg::M_DATA_W-1:0]     m_tdata,   // bin_index, bin_lower_edge,
                                                         // density, degenerate
    output logic                              m_tuser,   // kind
    output logic                              m_tlast    // last
);
    import warh_pkg::*;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_div_start;
    logic [DEN_W-1:0]  w_div_rem;
    logic [LOW_W-1:0]  w_div_low;
    logic [STEP_W-1:0] w_div_steps;
    logic [DEN_W-1:0]  w_div_den;
    logic [LOW_W-1:0]  w_div_q;
    logic              w_div_done;
    logic              w_div_busy;

    warh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    warh_dp #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_BINS      (MAX_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_data    (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_div_start (w_div_start),
        .o_div_rem   (w_div_rem),
        .o_div_low   (w_div_low),
        .o_div_steps (w_div_steps),
        .o_div_den   (w_div_den),
        .i_div_q     (w_div_q),
        .i_div_done  (w_div_done)
    );

    warh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_div_rem),
        .i_low   (w_div_low),
        .i_steps (w_div_steps),
        .i_den   (w_div_den),
        .o_q     (w_div_q),
        .o_done  (w_div_done),
        .o_busy  (w_div_busy)
    );

`ifndef SYNTHESIS
    a_div_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |-> !w_div_busy) else $error("word taken during divide");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy) else $error("divider restart");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free) else $error("output word overwritten");
`endif

endmodule

>>> tb/weighted_auto_range_histogram_core_test.sv
// self-checking testbench for the weighted auto-range histogram core
module weighted_auto_range_histogram_core_test;
    import warh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // one input word and one result word as seen on the streams
    typedef struct {
        logic        req;
        logic [31:0] vel;
        logic [31:0] wgt;
        logic        alive;
        logic        last;
    } t_particle;

    typedef struct {
        logic        kind;
        logic [5:0]  idx;
        logic [31:0] edge_v;
        logic [47:0] dens;
        logic        degen;
        logic        last;
    } t_report;

    // histogram predictor and store of expected reports
    class t_histogram_board;
        logic [6:0]        bins_reg;
        logic [31:0]       inv_reg;
        logic [31:0]       vel_store[$];
        logic [31:0]       wgt_store[$];
        int                vmin, vmax;
        logic [47:0]       dens[64];
        int                bmin;
        longint unsigned   brange;
        int unsigned       bbins;
        bit                bdegen;
        t_report           expected_reports[$];
        int                mismatches;
        int                reports_seen;

        function new();
            bins_reg = BIN_COUNT_RST;
            inv_reg = INV_VOL_RST;
            vmin = 32'sh7fffffff;
            vmax = 32'sh80000000;
            foreach (dens[i]) dens[i] = '0;
            bmin = 0;
            brange = 1;
            bbins = 1;
            bdegen = 1;
            mismatches = 0;
            reports_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == REG_BIN_COUNT) bins_reg = val[6:0];
            else inv_reg = val;
        endfunction

        function int unsigned find_bin(int v);
            longint d;
            longint unsigned q;
            d = longint'(v) - longint'(bmin);
            if (d < 0) return 0;
            q = (longint'(d) * bbins) / brange;
            if (q > bbins - 1) q = bbins - 1;
            return q;
        endfunction

        function logic [31:0] edge_of(int unsigned k);
            longint unsigned off;
            off = (longint'(k) * brange) / bbins;
            return 32'(longint'({32'd0, bmin}) + off);
        endfunction

        function void push_report(logic kind, int unsigned k, bit last);
            t_report r;
            r.kind = kind;
            r.idx = k[5:0];
            r.edge_v = edge_of(k);
            r.dens = dens[k];
            r.degen = bdegen;
            r.last = last;
            expected_reports.push_back(r);
        endfunction

        // note an accepted input word and predict what it causes
        function void note_word(t_particle p);
            longint unsigned sums[64];
            logic [127:0]    prod, q;
            int unsigned     n, k;
            int              cnt;
            if (p.req == REQ_QUERY) begin
                push_report(KIND_QUERY, find_bin(int'(p.vel)), 1);
                return;
            end
            if (p.alive && vel_store.size() < DEF_MAX_PARTICLES) begin
                vel_store.push_back(p.vel);
                wgt_store.push_back(p.wgt);
                if (int'(p.vel) < vmin) vmin = int'(p.vel);
                if (int'(p.vel) > vmax) vmax = int'(p.vel);
            end
            if (!p.last) return;
            n = bins_reg;
            if (n < 1) n = 1;
            if (n > 64) n = 64;
            cnt = vel_store.size();
            bbins = n;
            bdegen = (cnt == 0) || (vmax == vmin);
            bmin = (cnt == 0) ? 0 : vmin;
            brange = bdegen ? n : longint'(longint'(vmax) - longint'(vmin));
            foreach (sums[i]) sums[i] = 0;
            for (int i = 0; i < cnt; i++) begin
                k = find_bin(int'(vel_store[i]));
                sums[k] += wgt_store[i];
            end
            for (int i = 0; i < 64; i++) begin
                if (i < n) begin
                    prod = 128'(sums[i] * n) * 128'(inv_reg);
                    q = prod / 128'(brange);
                    dens[i] = (q > 128'(DENS_MAX)) ? DENS_MAX : q[47:0];
                end else begin
                    dens[i] = '0;
                end
            end
            for (int i = 0; i < n; i++) push_report(KIND_BIN, i, i == n - 1);
            vel_store.delete();
            wgt_store.delete();
            vmin = 32'sh7fffffff;
            vmax = 32'sh80000000;
        endfunction

        // compare one received word with the oldest expectation
        function void check_report(t_report got);
            t_report e;
            reports_seen++;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d bin %0d", got.kind, got.idx);
                return;
            end
            e = expected_reports.pop_front();
            if (got.kind !== e.kind || got.idx !== e.idx || got.edge_v !== e.edge_v ||
                got.dens !== e.dens || got.degen !== e.degen || got.last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp kind %0d bin %0d edge %h dens %h degen %0d",
                              " last %0d / got kind %0d bin %0d edge %h dens %h degen %0d",
                              " last %0d"},
                             e.kind, e.idx, e.edge_v, e.dens, e.degen, e.last,
                             got.kind, got.idx, got.edge_v, got.dens, got.degen, got.last);
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 0;
    logic                  s_tlast = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    t_histogram_board board = new();
    bit no_idle = 0;
    bit hold_req = 0;
    int words_sent = 0;
    int passes = 0;

    weighted_auto_range_histogram_core uut (.*);

    always #2 i_clk = ~i_clk;

    // run limit
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // send one word, idling first by a random gap
    task automatic send_word(t_particle p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata <= {7'd0, p.alive, p.wgt, p.vel};
        s_tuser <= p.req;
        s_tlast <= p.last;
        do @(posedge i_clk); while (!s_tready);
        board.note_word(p);
        words_sent++;
        if (p.req == REQ_LOAD && p.last) passes++;
    endtask

    task automatic load(logic [31:0] v, logic [31:0] w, logic alive, logic last);
        t_particle p;
        p = '{REQ_LOAD, v, w, alive, last};
        send_word(p);
    endtask

    task automatic query(logic [31:0] v);
        t_particle p;
        p = '{REQ_QUERY, v, $urandom, $urandom_range(0, 1), $urandom_range(0, 1)};
        send_word(p);
    endtask

    // wait until all reports are in and the block has settled, then write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        s_tvalid <= 0;
        while (board.expected_reports.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.write_reg(idx, val);
    endtask

    // one run of random particles, mostly live, with queries mixed in
    task automatic random_run(int len);
        logic [31:0] base, v;
        int shift;
        base = $urandom;
        shift = $urandom_range(0, 31);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) query($urandom_range(0, 1) ? $urandom : base);
            v = $urandom_range(0, 3) == 0 ? $urandom : base + ($urandom >> shift);
            load(v, $urandom >> $urandom_range(0, 31), $urandom_range(0, 7) != 0, i == len - 1);
        end
        repeat ($urandom_range(0, 3)) query($urandom_range(0, 1) ? $urandom : base);
    endtask

    // receiver with random stalls and one long hold-off on request
    initial begin
        t_report got;
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (hold_req) begin
                gap = 600;
                hold_req = 0;
            end
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1;
            do @(posedge i_clk); while (!m_tvalid);
            got.kind = m_tuser;
            got.idx = m_tdata[5:0];
            got.edge_v = m_tdata[37:6];
            got.dens = m_tdata[85:38];
            got.degen = m_tdata[86];
            got.last = m_tlast;
            board.check_report(got);
        end
    end

    // stimulus
    initial begin
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // query before any histogram exists
        query(32'h0);
        // full-scale velocities and weights, a dead particle in between
        load(32'h8000_0000, 32'hffff_ffff, 1, 0);
        load(32'h7fff_ffff, 32'h0000_0000, 1, 0);
        load(32'h1234_5678, 32'hffff_ffff, 0, 0);
        load(32'h0000_0000, 32'hffff_ffff, 1, 1);
        query(32'h8000_0000);
        query(32'h7fff_ffff);
        query(32'h0000_0000);
        // dead last particle with nothing live
        load(32'h0000_1000, 32'h0001_0000, 0, 1);
        query(32'hffff_ffff);
        // one live particle near the top: zero span, edges wrap
        write_reg(REG_BIN_COUNT, 32'd127);
        write_reg(REG_INV_VOL, 32'hffff_ffff);
        load(32'h7fff_fff0, 32'hffff_ffff, 1, 1);
        query(32'h7fff_ffff);
        query(32'h8000_0000);
        // bin count zero, smallest scale, below-min and above-top queries
        write_reg(REG_BIN_COUNT, 32'd0);
        write_reg(REG_INV_VOL, 32'd1);
        load(32'h0001_0000, 32'h0100_0000, 1, 0);
        load(32'h0005_0000, 32'h0200_0000, 1, 1);
        query(32'h0000_0000);
        query(32'h0009_0000);

        // random runs across several register settings
        while (words_sent < 170) begin
            case ($urandom_range(0, 3))
                0: n = 1;
                1: n = 64;
                2: n = $urandom_range(65, 127);
                default: n = $urandom_range(0, 20);
            endcase
            write_reg(REG_BIN_COUNT, n);
            case ($urandom_range(0, 3))
                0: write_reg(REG_INV_VOL, 32'd1);
                1: write_reg(REG_INV_VOL, 32'hffff_ffff);
                default: write_reg(REG_INV_VOL, $urandom | 32'd1);
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) hold_req = 1;
            repeat ($urandom_range(1, 3)) random_run($urandom_range(1, 16));
        end
        no_idle = 0;
        // long receiver hold-off while loads keep coming
        hold_req = 1;
        random_run(12);
        random_run(20);

        s_tvalid <= 0;
        while (board.expected_reports.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d histogram passes and %0d reports from %0d input words",
                 passes, board.reports_seen, words_sent);
        $display("register extremes, degenerate spans, wrapped edges, queries and stalls");
        if (board.mismatches == 0 && board.expected_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("mismatches: %0d", board.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/warh_pkg.sv
hdl/warh_div.sv
hdl/warh_ctrl.sv
hdl/warh_dp.sv
hdl/weighted_auto_range_histogram_core.sv
tb/weighted_auto_range_histogram_core_test.sv
